### hdl/bilinear_texture_sampler_macros.svh
// Assertion macros for the bilinear texture sampler.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef BILINEAR_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_MACROS_SVH

`ifndef SYNTH
// Plain property that must hold outside reset.
`define BTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define BTS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication.
`define BTS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define BTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define BTS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### hdl/bts_pkg.sv
// Shared constants, types and the channel lerp function of the texture sampler.
// No dependencies; the interfaces, the axis unit, the filter and the top level use it.
`timescale 1ns / 1ps

package bts_pkg;

  // Texture geometry.
  localparam int MAX_SIDE    = 256;
  localparam int TEXEL_COUNT = 65536;
  localparam int SIDE_W      = $clog2(MAX_SIDE) + 1;
  localparam int IDX_W       = $clog2(MAX_SIDE);
  localparam int ADDR_W      = $clog2(TEXEL_COUNT);
  localparam int ROW_W       = IDX_W + SIDE_W;

  // Field widths of the channels.
  localparam int TEXEL_IDX_W = 16;
  localparam int TEXEL_W     = 32;
  localparam int COORD_W     = 17;
  localparam int FRAC_W      = 16;
  localparam int CHAN_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Operation codes of a request.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = CFG_IDX_W'(1);

  // Capture and mix strobes from the sequencer to the filter.
  typedef struct packed {
    logic cap_lt;
    logic cap_rt;
    logic cap_lb;
    logic hmix;
  } filt_ctrl_t;

  // A side register of zero acts as one; larger than MAX_SIDE saturates.
  function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] raw);
    logic [SIDE_W-1:0] res;
    if (raw == '0) begin
      res = SIDE_W'(1);
    end else if (raw > SIDE_W'(MAX_SIDE)) begin
      res = SIDE_W'(MAX_SIDE);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  // l + (r - l) * w / 2^16, rounded down; the sum never goes negative.
  function automatic logic [CHAN_W-1:0] lerp8(logic [CHAN_W-1:0] l, logic [CHAN_W-1:0] r,
                                              logic [FRAC_W-1:0] w);
    logic signed [CHAN_W:0]               diff;
    logic signed [CHAN_W+FRAC_W+1:0]      prod;
    logic signed [CHAN_W+FRAC_W+1:0]      acc;
    diff = $signed({1'b0, r}) - $signed({1'b0, l});
    prod = diff * $signed({1'b0, w});
    acc  = prod + $signed({2'b00, l, {FRAC_W{1'b0}}});
    return acc[FRAC_W+CHAN_W-1:FRAC_W];
  endfunction

endpackage

### hdl/bts_if.sv
// Channel interfaces of the texture sampler: request, result and configuration.
// Depends on bts_pkg for the field widths.
`timescale 1ns / 1ps

// Request channel: texel writes and sample requests.
interface bts_req_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [bts_pkg::TEXEL_IDX_W-1:0]   texel_index;
  logic [bts_pkg::TEXEL_W-1:0]       texel_rgba;
  logic [bts_pkg::COORD_W-1:0]       u_coord;
  logic [bts_pkg::COORD_W-1:0]       v_coord;

  modport source (output valid, op, texel_index, texel_rgba, u_coord, v_coord,
                  input ready);
  modport sink (input valid, op, texel_index, texel_rgba, u_coord, v_coord,
                output ready);
endinterface

// Result channel: one filtered RGBA color per sample request.
interface bts_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bts_pkg::CHAN_W-1:0]   red;
  logic [bts_pkg::CHAN_W-1:0]   green;
  logic [bts_pkg::CHAN_W-1:0]   blue;
  logic [bts_pkg::CHAN_W-1:0]   alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

// Configuration write channel.
interface bts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bts_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [bts_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### hdl/bts_texel_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module bts_texel_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle: a write or a read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bts_axis.sv
// One texture axis: scales a Q1.16 coordinate by the side, splits it into
// clamped texel indexes and a weight. Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_axis (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [bts_pkg::COORD_W-1:0]  coord_i,
  input  logic [bts_pkg::SIDE_W-1:0]   side_i,
  output logic [bts_pkg::IDX_W-1:0]    i0_o,
  output logic [bts_pkg::IDX_W-1:0]    i1_o,
  output logic [bts_pkg::FRAC_W-1:0]   frac_o
);
  import bts_pkg::*;

  localparam int POS_W = COORD_W + SIDE_W;
  localparam int IP_W  = POS_W - FRAC_W;

  logic [POS_W-1:0]  pos;
  logic [IP_W-1:0]   ip;
  logic [SIDE_W-1:0] last;
  logic              at_edge;
  logic [IDX_W-1:0]  i0_d, i1_d;
  logic [IDX_W-1:0]  i0_q, i1_q;
  logic [FRAC_W-1:0] frac_q;

  // Position in texels, Q.16.
  assign pos     = POS_W'(coord_i) * POS_W'(side_i);
  assign ip      = pos[POS_W-1:FRAC_W];
  assign last    = side_i - SIDE_W'(1);
  assign at_edge = ip >= IP_W'(last);

  // At or past the last texel both neighbors are the edge texel.
  always_comb begin
    if (at_edge) begin
      i0_d = last[IDX_W-1:0];
      i1_d = last[IDX_W-1:0];
    end else begin
      i0_d = ip[IDX_W-1:0];
      i1_d = ip[IDX_W-1:0] + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i0_q   <= i0_d;
      i1_q   <= i1_d;
      frac_q <= pos[FRAC_W-1:0];
    end
  end

  assign i0_o   = i0_q;
  assign i1_o   = i1_q;
  assign frac_o = frac_q;

endmodule

### hdl/bts_filter.sv
// Bilinear filter datapath: holds three fetched texels, mixes both rows
// horizontally, then mixes the rows vertically. Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_filter (
  input  logic                         clk_i,
  input  bts_pkg::filt_ctrl_t          ctrl_i,
  input  logic [bts_pkg::TEXEL_W-1:0]  texel_i,
  input  logic [bts_pkg::FRAC_W-1:0]   fx_i,
  input  logic [bts_pkg::FRAC_W-1:0]   fy_i,
  output logic [bts_pkg::TEXEL_W-1:0]  rgba_o
);
  import bts_pkg::*;

  localparam int NCHAN = TEXEL_W / CHAN_W;

  logic [TEXEL_W-1:0] lt_q, rt_q, lb_q;
  logic [TEXEL_W-1:0] top_d, bot_d;
  logic [TEXEL_W-1:0] top_q, bot_q;

  // Texels arrive one per cycle from the memory.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_lt) begin
      lt_q <= texel_i;
    end
    if (ctrl_i.cap_rt) begin
      rt_q <= texel_i;
    end
    if (ctrl_i.cap_lb) begin
      lb_q <= texel_i;
    end
  end

  // Horizontal mix of both rows; the lower-right texel comes straight from memory.
  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      top_d[c*CHAN_W +: CHAN_W] = lerp8(lt_q[c*CHAN_W +: CHAN_W],
                                        rt_q[c*CHAN_W +: CHAN_W], fx_i);
      bot_d[c*CHAN_W +: CHAN_W] = lerp8(lb_q[c*CHAN_W +: CHAN_W],
                                        texel_i[c*CHAN_W +: CHAN_W], fx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.hmix) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

  // Vertical mix; the output register of the top level registers the result.
  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      rgba_o[c*CHAN_W +: CHAN_W] = lerp8(top_q[c*CHAN_W +: CHAN_W],
                                         bot_q[c*CHAN_W +: CHAN_W], fy_i);
    end
  end

endmodule

### hdl/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: configuration, sequencer, texel
// memory and output register. Depends on bts_pkg, bts_if, bts_texel_ram,
// bts_axis, bts_filter and the assertion macro header.
//
// Usage:
//   req carries write and sample requests. A write (op = 0) stores texel_rgba
//   at texel_index in the texel memory and gives no result.
//   A sample (op = 1) filters the four texels around (u_coord, v_coord) with
//   clamp to edge and returns one RGBA color on rsp.
//   cfg sets tex_width (index 0) and tex_height (index 1); it is always ready
//   and must only be written while no sample is in flight.
// Sample sequence:
//   A sample passes the idle state that takes it, one state to scale the
//   coordinates, one for the row bases, four reads of the single-port texel
//   memory, one that takes the last read data and mixes horizontally, and one
//   vertical mix. The result becomes valid in the same cycle that req.ready
//   returns.
// Reset and stall:
//   Reset returns the sequencer to idle, drops rsp.valid and sets both sides
//   to 256. Texel memory is not cleared: texels must be written before use.
//   A waiting result does not block new requests; a second result waits in
//   the vertical mix step until the output register is free.
`timescale 1ns / 1ps
`include "bilinear_texture_sampler_macros.svh"

module bilinear_texture_sampler (
  input  logic  clk_i,
  input  logic  rst_ni,
  bts_req_if.sink   req,
  bts_rsp_if.source rsp,
  bts_cfg_if.sink   cfg
);
  import bts_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_POS  = 4'd1;
  localparam logic [3:0] ST_ROW  = 4'd2;
  localparam logic [3:0] ST_RD0  = 4'd3;
  localparam logic [3:0] ST_RD1  = 4'd4;
  localparam logic [3:0] ST_RD2  = 4'd5;
  localparam logic [3:0] ST_RD3  = 4'd6;
  localparam logic [3:0] ST_HMIX = 4'd7;
  localparam logic [3:0] ST_VMIX = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [SIDE_W-1:0]  width_q, height_q;
  logic [SIDE_W-1:0]  side_w, side_h;
  logic [COORD_W-1:0] u_q, v_q;
  logic [IDX_W-1:0]   x0, x1, y0, y1;
  logic [FRAC_W-1:0]  fx, fy;
  logic [ROW_W-1:0]   row0_q, row1_q;
  logic [ROW_W-1:0]   addr_sum;
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_en, ram_we;
  logic [TEXEL_W-1:0] ram_rdata;
  logic [TEXEL_W-1:0] filt_rgba;
  filt_ctrl_t         fctrl;
  logic [TEXEL_W-1:0] out_rgba_q;
  logic               out_valid_q;
  logic               out_free;
  logic               req_fire, cfg_fire, write_fire;

  assign req_fire   = req.valid && req.ready;
  assign cfg_fire   = cfg.valid && cfg.ready;
  assign write_fire = req_fire && (req.op == OP_WRITE)
                      && (32'(req.texel_index) < 32'(TEXEL_COUNT));
  assign out_free   = !out_valid_q || rsp.ready;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_W'(MAX_SIDE);
      height_q <= SIDE_W'(MAX_SIDE);
    end else if (cfg_fire) begin
      if (cfg.reg_index == REG_TEX_WIDTH) begin
        width_q <= cfg.wdata[SIDE_W-1:0];
      end
      if (cfg.reg_index == REG_TEX_HEIGHT) begin
        height_q <= cfg.wdata[SIDE_W-1:0];
      end
    end
  end

  assign side_w = clamp_side(width_q);
  assign side_h = clamp_side(height_q);

  // Sequencer.
  assign req.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire && (req.op == OP_SAMPLE)) begin
          state_d = ST_POS;
        end
      end
      ST_POS:  state_d = ST_ROW;
      ST_ROW:  state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_HMIX;
      ST_HMIX: state_d = ST_VMIX;
      ST_VMIX: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Coordinates of the accepted sample.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      u_q <= req.u_coord;
      v_q <= req.v_coord;
    end
  end

  // Coordinate scaling, one unit per axis.
  bts_axis u_axis_x (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_POS),
    .coord_i(u_q),
    .side_i (side_w),
    .i0_o   (x0),
    .i1_o   (x1),
    .frac_o (fx)
  );

  bts_axis u_axis_y (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_POS),
    .coord_i(v_q),
    .side_i (side_h),
    .i0_o   (y0),
    .i1_o   (y1),
    .frac_o (fy)
  );

  // Row base addresses.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROW) begin
      row0_q <= ROW_W'(y0) * ROW_W'(side_w);
      row1_q <= ROW_W'(y1) * ROW_W'(side_w);
    end
  end

  // Memory address: a write in idle, otherwise the four neighbor reads.
  always_comb begin
    case (state_q)
      ST_RD0:  addr_sum = row0_q + ROW_W'(x0);
      ST_RD1:  addr_sum = row0_q + ROW_W'(x1);
      ST_RD2:  addr_sum = row1_q + ROW_W'(x0);
      ST_RD3:  addr_sum = row1_q + ROW_W'(x1);
      default: addr_sum = '0;
    endcase
  end

  assign ram_we   = write_fire;
  assign ram_en   = write_fire || (state_q inside {[ST_RD0:ST_RD3]});
  assign ram_addr = ram_we ? ADDR_W'(req.texel_index) : addr_sum[ADDR_W-1:0];

  bts_texel_ram #(
    .DEPTH(TEXEL_COUNT),
    .WIDTH(TEXEL_W)
  ) u_texel_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(req.texel_rgba),
    .rdata_o(ram_rdata)
  );

  // Filter strobes follow the read data, in the cycle after each read address.
  always_comb begin
    fctrl        = '0;
    fctrl.cap_lt = (state_q == ST_RD1);
    fctrl.cap_rt = (state_q == ST_RD2);
    fctrl.cap_lb = (state_q == ST_RD3);
    fctrl.hmix   = (state_q == ST_HMIX);
  end

  bts_filter u_filter (
    .clk_i  (clk_i),
    .ctrl_i (fctrl),
    .texel_i(ram_rdata),
    .fx_i   (fx),
    .fy_i   (fy),
    .rgba_o (filt_rgba)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_VMIX) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_VMIX) && out_free) begin
      out_rgba_q <= filt_rgba;
    end
  end

  assign rsp.valid = out_valid_q;
  assign rsp.red   = out_rgba_q[0*CHAN_W +: CHAN_W];
  assign rsp.green = out_rgba_q[1*CHAN_W +: CHAN_W];
  assign rsp.blue  = out_rgba_q[2*CHAN_W +: CHAN_W];
  assign rsp.alpha = out_rgba_q[3*CHAN_W +: CHAN_W];

  // Checks.
  `BTS_ASSERT(a_ram_one_access, clk_i, rst_ni,
    !(ram_we && (state_q != ST_IDLE)), "texel write outside idle")
  `BTS_ASSERT_NEXT(a_sample_starts, clk_i, rst_ni,
    req_fire && (req.op == OP_SAMPLE), state_q == ST_POS, "sample did not start scaling")
  `BTS_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, (state_q == ST_VMIX) && out_free,
    rsp.valid && (state_q == ST_IDLE), "finished sample not presented")
  `BTS_ASSERT_IMPL(a_neighbor_x, clk_i, rst_ni, state_q == ST_ROW,
    (x1 == x0) || (x1 == x0 + IDX_W'(1)), "horizontal neighbor not adjacent")

endmodule
